// ===== design/gpad_ar_pkg.sv =====
// Package for the gamepad button autorepeat block: field widths, style codes,
// raw and logical button positions, and the button remap functions.
// No dependencies.
package gpad_ar_pkg;

    localparam int PADS_DEF    = 8;
    localparam int BUTTONS_DEF = 11;

    localparam int PAD_W    = 3;
    localparam int STYLE_W  = 3;
    localparam int RAW_W    = 16;
    localparam int STICK_W  = 16;
    localparam int FT_W     = 12;
    localparam int LOG_W    = 11;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 1;
    localparam int HOLD_W   = 21;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] FIRST_DELAY_RST     = 20'd8000;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 20'd1600;

    localparam logic [STYLE_W-1:0] STYLE_NONE     = 3'd0;
    localparam logic [STYLE_W-1:0] STYLE_HANDHELD = 3'd1;
    localparam logic [STYLE_W-1:0] STYLE_LEFT     = 3'd2;
    localparam logic [STYLE_W-1:0] STYLE_RIGHT    = 3'd3;
    localparam logic [STYLE_W-1:0] STYLE_DUAL     = 3'd4;
    localparam logic [STYLE_W-1:0] STYLE_FULL     = 3'd5;

    localparam logic signed [STICK_W-1:0] HALF_POS = 16'sd16384;
    localparam logic signed [STICK_W-1:0] HALF_NEG = -16'sd16384;
    localparam logic signed [STICK_W-1:0] STICK_MIN = 16'sh8000;
    localparam logic signed [STICK_W-1:0] STICK_MAX = 16'sh7FFF;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // logical buttons
    localparam int L_START = 0;
    localparam int L_A     = 1;
    localparam int L_B     = 2;
    localparam int L_X     = 3;
    localparam int L_Y     = 4;
    localparam int L_L1    = 5;
    localparam int L_R1    = 6;
    localparam int L_UP    = 7;
    localparam int L_DOWN  = 8;
    localparam int L_LEFT  = 9;
    localparam int L_RIGHT = 10;

    // raw buttons
    localparam int R_A     = 0;
    localparam int R_B     = 1;
    localparam int R_X     = 2;
    localparam int R_Y     = 3;
    localparam int R_L     = 4;
    localparam int R_R     = 5;
    localparam int R_PLUS  = 6;
    localparam int R_MINUS = 7;
    localparam int R_LEFT  = 8;
    localparam int R_UP    = 9;
    localparam int R_RIGHT = 10;
    localparam int R_DOWN  = 11;
    localparam int R_LSL   = 12;
    localparam int R_LSR   = 13;
    localparam int R_RSL   = 14;
    localparam int R_RSR   = 15;

    function automatic logic signed [STICK_W-1:0] neg_sat(input logic signed [STICK_W-1:0] v);
        neg_sat = (v == STICK_MIN) ? STICK_MAX : -v;
    endfunction

    function automatic logic [LOG_W-1:0] map_full(input logic [RAW_W-1:0] r);
        logic [LOG_W-1:0] m;
        m = '0;
        m[L_START] = r[R_PLUS] | r[R_MINUS];
        m[L_A]     = r[R_A];
        m[L_B]     = r[R_B];
        m[L_X]     = r[R_X];
        m[L_Y]     = r[R_Y];
        m[L_L1]    = r[R_L];
        m[L_R1]    = r[R_R];
        m[L_UP]    = r[R_UP];
        m[L_DOWN]  = r[R_DOWN];
        m[L_LEFT]  = r[R_LEFT];
        m[L_RIGHT] = r[R_RIGHT];
        map_full = m;
    endfunction

    function automatic logic [LOG_W-1:0] map_left(input logic [RAW_W-1:0] r);
        logic [LOG_W-1:0] m;
        m = '0;
        m[L_START] = r[R_MINUS];
        m[L_A]     = r[R_DOWN];
        m[L_B]     = r[R_LEFT];
        m[L_X]     = r[R_RIGHT];
        m[L_Y]     = r[R_UP];
        m[L_L1]    = r[R_LSL];
        m[L_R1]    = r[R_LSR];
        map_left = m;
    endfunction

    function automatic logic [LOG_W-1:0] map_right(input logic [RAW_W-1:0] r);
        logic [LOG_W-1:0] m;
        m = '0;
        m[L_START] = r[R_PLUS];
        m[L_A]     = r[R_X];
        m[L_B]     = r[R_A];
        m[L_X]     = r[R_Y];
        m[L_Y]     = r[R_B];
        m[L_L1]    = r[R_RSL];
        m[L_R1]    = r[R_RSR];
        map_right = m;
    endfunction

endpackage

// ===== design/gamepad_button_autorepeat_top.sv =====
// Gamepad button sampler with typematic auto-repeat, one pad sample per transaction.
// Depends on gpad_ar_pkg.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+-------------------------------
//  sample   | in  | s_axis_tvalid / s_axis_tready   | s_axis_tdata (72 bits)
//  result   | out | m_axis_tvalid / m_axis_tready   | m_axis_tdata (88 bits)
//  config   | in  | i_cfg_we                        | i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained while m_axis_tready stays high; a sample passes the input
// register, then the result register, before it is offered on m_axis. Per-pad state
// is read and written in the cycle a sample moves from the input register to the result
// register, so samples for the same pad may follow back to back. Synchronous active-low
// reset clears all pad state and restores the register defaults. A stalled result holds
// the input register, which accepts a new sample only as the stage ahead frees up.
module gamepad_button_autorepeat_top #(
    parameter int PADS    = gpad_ar_pkg::PADS_DEF,
    parameter int BUTTONS = gpad_ar_pkg::BUTTONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pad_index[2:0], style[5:3], connected[6], raw_buttons[22:7],
    // raw_stick_x[38:23], raw_stick_y[54:39], frame_time[66:55], zero[71:67]
    input  logic [gpad_ar_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_pad[2:0], active[3], held[14:4], pressed[25:15], released[36:26],
    // repeat_fire[47:37], stick_x[63:48], stick_y[79:64], connected_count[83:80],
    // zero[87:84]
    output logic [gpad_ar_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [gpad_ar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gpad_ar_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int PW = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int IW = (PW > gpad_ar_pkg::PAD_W) ? PW : gpad_ar_pkg::PAD_W;
    localparam int HW = gpad_ar_pkg::HOLD_W;
    localparam int LW = gpad_ar_pkg::LOG_W;
    localparam int SW = gpad_ar_pkg::STICK_W;

    // configuration
    logic [gpad_ar_pkg::CFG_W-1:0] r_first_delay;
    logic [gpad_ar_pkg::CFG_W-1:0] r_repeat_interval;

    // per-pad state
    logic [BUTTONS-1:0]   r_held   [PADS];
    logic [BUTTONS-1:0]   r_first  [PADS];
    logic                 r_active [PADS];
    logic signed [SW-1:0] r_sx     [PADS];
    logic signed [SW-1:0] r_sy     [PADS];
    logic [HW-1:0]        r_hold   [PADS][BUTTONS];
    logic [gpad_ar_pkg::CNT_W-1:0] r_cnt;

    // pipeline registers
    logic                                r_in_valid;
    logic [gpad_ar_pkg::IN_DATA_W-1:0]   r_in_data;
    logic                                r_out_valid;
    logic [gpad_ar_pkg::OUT_DATA_W-1:0]  r_out_data;

    // unpacked sample
    logic [gpad_ar_pkg::PAD_W-1:0]   in_pad;
    logic [gpad_ar_pkg::STYLE_W-1:0] in_style;
    logic                            in_conn;
    logic [gpad_ar_pkg::RAW_W-1:0]   in_raw;
    logic signed [SW-1:0]            in_sx;
    logic signed [SW-1:0]            in_sy;
    logic [gpad_ar_pkg::FT_W-1:0]    in_ft;

    logic [IW-1:0] pad_ext;
    logic [PW-1:0] idx;
    logic          pad_ok;
    logic          style_ok;
    logic          live;
    logic          in_adv;

    logic [BUTTONS-1:0]   prev;
    logic [BUTTONS-1:0]   now;
    logic [BUTTONS-1:0]   rep;
    logic [BUTTONS-1:0]   n_first;
    logic                 n_active;
    logic signed [SW-1:0] n_sx;
    logic signed [SW-1:0] n_sy;
    logic [HW-1:0]        n_hold [BUTTONS];
    logic [gpad_ar_pkg::CNT_W-1:0] n_cnt;
    logic [gpad_ar_pkg::OUT_DATA_W-1:0] n_out_data;

    assign in_pad   = r_in_data[2:0];
    assign in_style = r_in_data[5:3];
    assign in_conn  = r_in_data[6];
    assign in_raw   = r_in_data[22:7];
    assign in_sx    = r_in_data[38:23];
    assign in_sy    = r_in_data[54:39];
    assign in_ft    = r_in_data[66:55];

    assign pad_ext  = IW'(in_pad);
    assign idx      = pad_ext[PW-1:0];
    assign pad_ok   = (32'(in_pad) < PADS);
    assign style_ok = (in_style >= gpad_ar_pkg::STYLE_HANDHELD)
                   && (in_style <= gpad_ar_pkg::STYLE_FULL);
    assign live     = pad_ok && style_ok && in_conn;

    assign in_adv        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || in_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // remap, orient and direction buttons
    always_comb begin
        logic [LW-1:0]        mapped;
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        case (in_style)
            gpad_ar_pkg::STYLE_LEFT: begin
                x      = gpad_ar_pkg::neg_sat(in_sy);
                y      = gpad_ar_pkg::neg_sat(in_sx);
                mapped = gpad_ar_pkg::map_left(in_raw);
            end
            gpad_ar_pkg::STYLE_RIGHT: begin
                x      = in_sy;
                y      = in_sx;
                mapped = gpad_ar_pkg::map_right(in_raw);
            end
            default: begin
                x      = in_sx;
                y      = gpad_ar_pkg::neg_sat(in_sy);
                mapped = gpad_ar_pkg::map_full(in_raw);
            end
        endcase
        if (x >= gpad_ar_pkg::HALF_POS) begin
            mapped[gpad_ar_pkg::L_RIGHT] = 1'b1;
        end else if (x <= gpad_ar_pkg::HALF_NEG) begin
            mapped[gpad_ar_pkg::L_LEFT] = 1'b1;
        end
        if (y >= gpad_ar_pkg::HALF_POS) begin
            mapped[gpad_ar_pkg::L_DOWN] = 1'b1;
        end else if (y <= gpad_ar_pkg::HALF_NEG) begin
            mapped[gpad_ar_pkg::L_UP] = 1'b1;
        end

        prev = pad_ok ? r_held[idx] : '0;
        now  = live ? BUTTONS'(mapped) : '0;

        n_active = r_active[idx];
        n_sx     = r_sx[idx];
        n_sy     = r_sy[idx];
        if (pad_ok && style_ok) begin
            n_active = in_conn;
        end
        if (live) begin
            n_sx = x;
            n_sy = y;
        end
    end

    // per-button hold accumulators
    always_comb begin
        logic [HW:0]   sum;
        logic [HW-1:0] acc;
        logic [HW-1:0] lim;
        rep     = '0;
        n_first = r_first[idx];
        for (int i = 0; i < BUTTONS; i++) begin
            sum = {1'b0, r_hold[idx][i]} + (HW + 1)'(in_ft);
            acc = sum[HW] ? gpad_ar_pkg::HOLD_MAX : sum[HW-1:0];
            lim = r_first[idx][i] ? HW'(r_repeat_interval) : HW'(r_first_delay);
            n_hold[i] = r_hold[idx][i];
            if (live) begin
                if (now[i]) begin
                    if (!prev[i]) begin
                        rep[i] = 1'b1;
                    end else if (acc > lim) begin
                        rep[i]     = 1'b1;
                        n_first[i] = 1'b1;
                        acc        = acc - lim;
                    end
                    n_hold[i] = acc;
                end else begin
                    n_hold[i]  = '0;
                    n_first[i] = 1'b0;
                end
            end
        end
    end

    // frame count and result word
    always_comb begin
        n_cnt = (in_pad == '0) ? '0 : r_cnt;
        if (live && (n_cnt != gpad_ar_pkg::CNT_MAX)) begin
            n_cnt = n_cnt + 1'b1;
        end
        n_out_data          = '0;
        n_out_data[2:0]     = in_pad;
        n_out_data[3]       = pad_ok & n_active;
        n_out_data[14:4]    = now[LW-1:0];
        n_out_data[25:15]   = now[LW-1:0] & ~prev[LW-1:0];
        n_out_data[36:26]   = ~now[LW-1:0] & prev[LW-1:0];
        n_out_data[47:37]   = rep[LW-1:0];
        n_out_data[63:48]   = pad_ok ? n_sx : '0;
        n_out_data[79:64]   = pad_ok ? n_sy : '0;
        n_out_data[83:80]   = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay     <= gpad_ar_pkg::FIRST_DELAY_RST;
            r_repeat_interval <= gpad_ar_pkg::REPEAT_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gpad_ar_pkg::CFG_FIRST_DELAY:     r_first_delay     <= i_cfg_data;
                gpad_ar_pkg::CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int p = 0; p < PADS; p++) begin
                r_held[p]   <= '0;
                r_first[p]  <= '0;
                r_active[p] <= 1'b0;
                r_sx[p]     <= '0;
                r_sy[p]     <= '0;
                for (int b = 0; b < BUTTONS; b++) begin
                    r_hold[p][b] <= '0;
                end
            end
        end else if (in_adv) begin
            r_cnt <= n_cnt;
            if (pad_ok) begin
                r_held[idx]   <= now;
                r_first[idx]  <= n_first;
                r_active[idx] <= n_active;
                r_sx[idx]     <= n_sx;
                r_sy[idx]     <= n_sy;
                for (int b = 0; b < BUTTONS; b++) begin
                    r_hold[idx][b] <= n_hold[b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (in_adv) begin
                r_in_valid <= 1'b0;
            end
            if (in_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (in_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
